FILE: sv/pbsc_pkg.sv
package pbsc_pkg;

	localparam int MAX_ROWS = 8;
	localparam int MAX_COLS = 8;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int IDX_W    = 3;
	localparam int SIZE_W   = 4;
	localparam int BYTE_W   = 8;
	localparam int CMD_W    = 3;

	localparam logic [CMD_W-1:0] CMD_LOAD_CELL    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_ROW_KEY = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOAD_COL_KEY = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ENCRYPT      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DECRYPT      = 3'd4;

	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	typedef enum logic [1:0] {
		ERR_OK          = 2'd0,
		ERR_NOT_IN_GRID = 2'd1,
		ERR_NOT_IN_KEY  = 2'd2,
		ERR_ODD_LENGTH  = 2'd3
	} err_t;

	// item broadcast to every row cell at transaction time
	typedef struct packed {
		logic              acc;
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  ri;
		logic [IDX_W-1:0]  ci;
		logic [BYTE_W-1:0] data;
		logic [COL_W-1:0]  col_sel;
	} bcast_t;

	// passed from cell to cell, first hit wins
	typedef struct packed {
		logic              found;
		logic [BYTE_W-1:0] rkey;
		logic [COL_W-1:0]  col;
		logic              kfound;
		logic [ROW_W-1:0]  krow;
		logic [BYTE_W-1:0] gbyte;
	} chain_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		err_t              err;
		logic              last;
	} result_t;

endpackage

FILE: sv/pbsc_cell.sv
module pbsc_cell
	import pbsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ROW_W-1:0]  row_id,
	input  logic [SIZE_W-1:0] grid_rows,
	input  logic [SIZE_W-1:0] grid_cols,
	input  logic [ROW_W-1:0]  pend_row,
	input  bcast_t            bc,
	input  chain_t            chain_in,
	output chain_t            chain_out
);

	logic [BYTE_W-1:0] row_q [MAX_COLS];
	logic [BYTE_W-1:0] rkey_q;

	logic              hit_d;
	logic [COL_W-1:0]  hcol_d;
	logic              hit_s1;
	logic [COL_W-1:0]  hcol_s1;
	logic              kmatch_s1;
	logic [BYTE_W-1:0] gbyte_s1;
	logic              in_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_COLS; c++) row_q[c] <= '0;
			rkey_q <= '0;
		end else if (bc.acc && int'(bc.ri) == int'(row_id)) begin
			if (bc.cmd == CMD_LOAD_CELL && int'(bc.ci) < MAX_COLS)
				row_q[bc.ci[COL_W-1:0]] <= bc.data;
			if (bc.cmd == CMD_LOAD_ROW_KEY)
				rkey_q <= bc.data;
		end
	end

	// first matching column in this row
	always_comb begin
		hit_d  = 1'b0;
		hcol_d = '0;
		for (int c = MAX_COLS - 1; c >= 0; c--) begin
			if (c < int'(grid_cols) && row_q[c] == bc.data) begin
				hit_d  = 1'b1;
				hcol_d = COL_W'(c);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bc.acc) begin
			hit_s1    <= hit_d;
			hcol_s1   <= hcol_d;
			kmatch_s1 <= (rkey_q == bc.data);
			gbyte_s1  <= row_q[bc.col_sel];
		end
	end

	assign in_use = int'(row_id) < int'(grid_rows);

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.found && in_use && hit_s1) begin
			chain_out.found = 1'b1;
			chain_out.rkey  = rkey_q;
			chain_out.col   = hcol_s1;
		end
		if (!chain_in.kfound && in_use && kmatch_s1) begin
			chain_out.kfound = 1'b1;
			chain_out.krow   = row_id;
		end
		if (row_id == pend_row)
			chain_out.gbyte = gbyte_s1;
	end

endmodule

FILE: sv/polybius_square_cipher.sv
// a transaction is registered in stage s1; its results move into the output buffer once it has room
// an encrypt gives two results, and they leave one at a time
// through the single output port; a new item is taken while results wait
// the grid search runs through a chain of row cells, one cell per row of the largest grid
// reset: grid, keys and decrypt pairing clear to zero, grid size returns to 5x5
module polybius_square_cipher
	import pbsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // row_index, col_index, data_byte, zero pad
	input  logic [2:0]  s_tuser,  // command
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte
	output logic [1:0]  m_tuser,  // error_code
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input int max_v);
		logic [SIZE_W-1:0] r;
		if (v == '0) r = SIZE_W'(1);
		else if (int'(v) > max_v) r = SIZE_W'(max_v);
		else r = v;
		return r;
	endfunction

	logic [SIZE_W-1:0] grid_rows_q;
	logic [SIZE_W-1:0] grid_cols_q;
	logic [BYTE_W-1:0] ckey_q [MAX_COLS];

	logic              in_acc;
	logic              out_acc;
	logic              advance;
	bcast_t            bc;
	logic [COL_W-1:0]  c_d;
	logic              cfound_d;

	logic              s1_valid_q;
	logic [CMD_W-1:0]  cmd_s1;
	logic              end_s1;
	logic              cfound_s1;

	logic              pair_q;
	logic              pbad_q;
	logic [ROW_W-1:0]  prow_q;

	chain_t            chain [MAX_ROWS+1];

	result_t           res0;
	result_t           res1;
	logic [1:0]        res_n;
	logic              pair_d;
	logic              pbad_d;
	logic [ROW_W-1:0]  prow_d;
	logic              bad2;

	result_t           ob0_q;
	result_t           ob1_q;
	logic [1:0]        ob_cnt_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !s1_valid_q;
	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;
	assign advance   = s1_valid_q && (ob_cnt_q == 2'd0 || (ob_cnt_q == 2'd1 && out_acc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= clamp_size(SIZE_W'(5), MAX_ROWS);
			grid_cols_q <= clamp_size(SIZE_W'(5), MAX_COLS);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= clamp_size(cfg_data, MAX_ROWS);
				REG_GRID_COLS: grid_cols_q <= clamp_size(cfg_data, MAX_COLS);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_COLS; c++) ckey_q[c] <= '0;
		end else if (in_acc && s_tuser == CMD_LOAD_COL_KEY && int'(s_tdata[2:0]) < MAX_COLS) begin
			ckey_q[s_tdata[COL_W-1:0]] <= s_tdata[13:6];
		end
	end

	// column key lookup for the second decrypt byte
	always_comb begin
		cfound_d = 1'b0;
		c_d      = '0;
		for (int c = MAX_COLS - 1; c >= 0; c--) begin
			if (c < int'(grid_cols_q) && ckey_q[c] == s_tdata[13:6]) begin
				cfound_d = 1'b1;
				c_d      = COL_W'(c);
			end
		end
	end

	always_comb begin
		bc.acc     = in_acc;
		bc.cmd     = s_tuser;
		bc.ri      = s_tdata[2:0];
		bc.ci      = s_tdata[5:3];
		bc.data    = s_tdata[13:6];
		bc.col_sel = c_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1    <= s_tuser;
			end_s1    <= s_tlast;
			cfound_s1 <= cfound_d;
		end
	end

	assign chain[0] = '0;

	for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
		pbsc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.row_id    (ROW_W'(r)),
			.grid_rows (grid_rows_q),
			.grid_cols (grid_cols_q),
			.pend_row  (prow_q),
			.bc        (bc),
			.chain_in  (chain[r]),
			.chain_out (chain[r+1])
		);
	end

	assign bad2 = pbad_q || !cfound_s1;

	always_comb begin
		res0   = '{data: '0, err: ERR_OK, last: 1'b1};
		res1   = '{data: '0, err: ERR_OK, last: 1'b1};
		res_n  = 2'd0;
		pair_d = pair_q;
		pbad_d = pbad_q;
		prow_d = prow_q;
		unique case (cmd_s1)
			CMD_ENCRYPT: begin
				if (chain[MAX_ROWS].found) begin
					res0  = '{data: chain[MAX_ROWS].rkey, err: ERR_OK, last: 1'b0};
					res1  = '{data: ckey_q[chain[MAX_ROWS].col], err: ERR_OK, last: 1'b1};
					res_n = 2'd2;
				end else begin
					res0  = '{data: '0, err: ERR_NOT_IN_GRID, last: 1'b1};
					res_n = 2'd1;
				end
			end
			CMD_DECRYPT: begin
				if (!pair_q) begin
					if (end_s1) begin
						res0   = '{data: '0, err: ERR_ODD_LENGTH, last: 1'b1};
						res_n  = 2'd1;
						pair_d = 1'b0;
						pbad_d = 1'b0;
						prow_d = '0;
					end else begin
						pair_d = 1'b1;
						pbad_d = !chain[MAX_ROWS].kfound;
						prow_d = chain[MAX_ROWS].kfound ? chain[MAX_ROWS].krow : '0;
					end
				end else begin
					if (bad2) res0 = '{data: '0, err: ERR_NOT_IN_KEY, last: 1'b1};
					else res0 = '{data: chain[MAX_ROWS].gbyte, err: ERR_OK, last: 1'b1};
					res_n  = 2'd1;
					pair_d = 1'b0;
					pbad_d = 1'b0;
					prow_d = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= 1'b0;
			pbad_q <= 1'b0;
			prow_q <= '0;
		end else if (advance) begin
			pair_q <= pair_d;
			pbad_q <= pbad_d;
			prow_q <= prow_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= 2'd0;
		end else if (advance) begin
			ob_cnt_q <= res_n;
		end else if (out_acc) begin
			ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ob0_q <= res0;
			ob1_q <= res1;
		end else if (out_acc) begin
			ob0_q <= ob1_q;
		end
	end

	assign m_tvalid = ob_cnt_q != 2'd0;
	assign m_tdata  = ob0_q.data;
	assign m_tuser  = ob0_q.err;
	assign m_tlast  = ob0_q.last;

endmodule

FILE: sv/pbsc_checker.sv
module pbsc_checker
	import pbsc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ERR_OK |-> m_tdata == '0)
		else $error("error result carries nonzero byte");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ERR_OK |-> m_tlast)
		else $error("error result not last");

	// one item in flight past the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on consecutive cycles");

	// a first result that is not last is followed by the second of its pair
	a_first_of_two: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("second result of a pair missing");

endmodule

bind polybius_square_cipher pbsc_checker u_pbsc_checker (.*);

FILE: bench/tb_polybius_square_cipher.sv
module tb_polybius_square_cipher;
	import pbsc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RESERVED_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RESERVED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RESERVED_7 = 3'd7;
	localparam int RAND_ITEMS = 480;
	localparam int BATCH_LEN = 24;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 400;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [BYTE_W-1:0] val;
		logic              eom;
	} item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // row_index, col_index, data_byte, zero pad
	logic [2:0]  s_tuser = '0;  // command
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // out_byte
	logic [1:0]  m_tuser;       // error_code
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [3:0]  cfg_data = '0;

	// shadow of the block state
	logic [BYTE_W-1:0] grid [MAX_ROWS][MAX_COLS] = '{default: '{default: 8'h00}};
	logic [BYTE_W-1:0] row_key [MAX_ROWS] = '{default: 8'h00};
	logic [BYTE_W-1:0] col_key [MAX_COLS] = '{default: 8'h00};
	int                rows_used = 5;
	int                cols_used = 5;
	logic              half_held = 1'b0;
	logic              held_bad = 1'b0;
	int                held_row = 0;

	item_t   cmd_feed [$];
	result_t out_due [$];
	item_t   cur_item;
	int      tx_wait = 0;
	int      rx_wait = 0;
	int      rx_hold_left = 0;
	bit      tx_idle_on = 1'b1;
	bit      rx_idle_on = 1'b1;
	int      mismatches = 0;
	int      rand_count = 0;
	int      stall_cycles = 0;
	int      plan_rows [6] = '{8, 1, 0, 15, 2, 7};
	int      plan_cols [6] = '{8, 1, 15, 0, 8, 3};

	polybius_square_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int clamp_size(logic [3:0] v, int max_size);
		if (v == 0) return 1;
		if (v > max_size) return max_size;
		return v;
	endfunction

	function automatic int key_pos(input logic [BYTE_W-1:0] key [MAX_ROWS], input int len,
			input logic [BYTE_W-1:0] b);
		for (int i = 0; i < len; i++)
			if (key[i] == b) return i;
		return len;
	endfunction

	function automatic void due(logic [BYTE_W-1:0] d, err_t e, logic l);
		result_t x;
		x.data = d;
		x.err = e;
		x.last = l;
		out_due.push_back(x);
	endfunction

	function automatic void square_step(item_t it);
		int r;
		int c;
		bit hit;
		case (it.cmd)
			CMD_LOAD_CELL: grid[it.row][it.col] = it.val;
			CMD_LOAD_ROW_KEY: row_key[it.row] = it.val;
			CMD_LOAD_COL_KEY: col_key[it.row] = it.val;
			CMD_ENCRYPT: begin
				hit = 1'b0;
				for (r = 0; r < rows_used && !hit; r++)
					for (c = 0; c < cols_used && !hit; c++)
						if (grid[r][c] == it.val) begin
							hit = 1'b1;
							due(row_key[r], ERR_OK, 1'b0);
							due(col_key[c], ERR_OK, 1'b1);
						end
				if (!hit) due(8'h00, ERR_NOT_IN_GRID, 1'b1);
			end
			CMD_DECRYPT: begin
				if (!half_held) begin
					r = key_pos(row_key, rows_used, it.val);
					if (it.eom) begin
						held_bad = 1'b0;
						held_row = 0;
						due(8'h00, ERR_ODD_LENGTH, 1'b1);
					end else begin
						half_held = 1'b1;
						held_bad = (r >= rows_used);
						held_row = held_bad ? 0 : r;
					end
				end else begin
					c = key_pos(col_key, cols_used, it.val);
					half_held = 1'b0;
					if (held_bad || c >= cols_used) due(8'h00, ERR_NOT_IN_KEY, 1'b1);
					else due(grid[held_row][c], ERR_OK, 1'b1);
					held_bad = 1'b0;
					held_row = 0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.cmd = 3'($urandom_range(0, 7));
		it.row = 3'($urandom_range(0, 7));
		it.col = 3'($urandom_range(0, 7));
		it.val = 8'($urandom_range(0, 255));
		it.eom = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic void push(logic [CMD_W-1:0] cmd, int row, int col, logic [7:0] val,
			logic eom);
		item_t it;
		it.cmd = cmd;
		it.row = 3'(row);
		it.col = 3'(col);
		it.val = val;
		it.eom = eom;
		cmd_feed.push_back(it);
	endfunction

	// fill the used part of the grid and both keys with random bytes
	function automatic void load_square();
		item_t it;
		for (int r = 0; r < rows_used; r++)
			for (int c = 0; c < cols_used; c++) begin
				it = rand_item();
				it.cmd = CMD_LOAD_CELL;
				it.row = 3'(r);
				it.col = 3'(c);
				cmd_feed.push_back(it);
			end
		for (int i = 0; i < MAX_ROWS; i++) begin
			it = rand_item();
			it.cmd = (i < rows_used) ? CMD_LOAD_ROW_KEY : CMD_LOAD_COL_KEY;
			it.row = 3'((i < rows_used) ? i : i - rows_used);
			if (i < rows_used || i - rows_used < cols_used) cmd_feed.push_back(it);
		end
		for (int i = 0; i < cols_used; i++) begin
			it = rand_item();
			it.cmd = CMD_LOAD_COL_KEY;
			it.row = 3'(i);
			cmd_feed.push_back(it);
		end
	endfunction

	// mostly encrypts and decrypt pairs drawn from the loaded square, some noise
	function automatic void random_batch(int n);
		item_t it;
		int sel;
		for (int k = 0; k < n; k++) begin
			it = rand_item();
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				it.cmd = CMD_ENCRYPT;
				if ($urandom_range(0, 4) != 0)
					it.val = grid[$urandom_range(0, rows_used - 1)][$urandom_range(0, cols_used - 1)];
				cmd_feed.push_back(it);
			end else if (sel < 85) begin
				it.cmd = CMD_DECRYPT;
				if ($urandom_range(0, 5) != 0) it.val = row_key[$urandom_range(0, rows_used - 1)];
				if ($urandom_range(0, 9) == 0) begin
					it.eom = 1'b1;
					cmd_feed.push_back(it);
				end else begin
					it.eom = 1'b0;
					cmd_feed.push_back(it);
					it = rand_item();
					it.cmd = CMD_DECRYPT;
					if ($urandom_range(0, 5) != 0) it.val = col_key[$urandom_range(0, cols_used - 1)];
					cmd_feed.push_back(it);
					k++;
				end
			end else if (sel < 93) begin
				it.cmd = 3'($urandom_range(0, 2));
				cmd_feed.push_back(it);
			end else begin
				cmd_feed.push_back(it);
			end
		end
		rand_count += n;
	endfunction

	task automatic settle();
		do @(negedge clk);
		while (cmd_feed.size() != 0 || s_tvalid || out_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(logic [3:0] rows_val, logic [3:0] cols_val);
		cfg_index <= REG_GRID_ROWS;
		cfg_data <= rows_val;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		rows_used = clamp_size(rows_val, MAX_ROWS);
		cfg_index <= REG_GRID_COLS;
		cfg_data <= cols_val;
		do @(posedge clk);
		while (!cfg_ready);
		cols_used = clamp_size(cols_val, MAX_COLS);
		cfg_valid <= 1'b0;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) square_step(cur_item);
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					s_tvalid <= 1'b0;
				end else if (cmd_feed.size() != 0) begin
					cur_item = cmd_feed.pop_front();
					s_tdata <= {2'b00, cur_item.val, cur_item.col, cur_item.row};
					s_tuser <= cur_item.cmd;
					s_tlast <= cur_item.eom;
					s_tvalid <= 1'b1;
					tx_wait = tx_idle_on ? $urandom_range(0, 7) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		result_t exp_res;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (out_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: out_byte %02h err %0d last %0b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					exp_res = out_due.pop_front();
					if (m_tdata !== exp_res.data || m_tuser !== exp_res.err ||
							m_tlast !== exp_res.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: out_byte %02h/%02h err %0d/%0d last %0b/%0b (exp/act)",
								exp_res.data, m_tdata, exp_res.err, m_tuser, exp_res.last, m_tlast);
					end
				end
				rx_wait = rx_idle_on ? $urandom_range(0, 7) : 0;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_polybius_square_cipher: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push(CMD_ENCRYPT, 0, 0, 8'h00, 1'b0);
		push(CMD_ENCRYPT, 7, 7, 8'hFF, 1'b1);
		push(CMD_DECRYPT, 0, 0, 8'h00, 1'b1);
		push(CMD_DECRYPT, 0, 0, 8'h00, 1'b0);
		push(CMD_DECRYPT, 7, 7, 8'h00, 1'b1);
		push(CMD_LOAD_CELL, 7, 7, 8'hFF, 1'b0);
		push(CMD_LOAD_CELL, 0, 1, 8'h80, 1'b1);
		push(CMD_LOAD_ROW_KEY, 7, 7, 8'hAA, 1'b0);
		push(CMD_LOAD_COL_KEY, 7, 0, 8'h55, 1'b1);
		push(CMD_LOAD_ROW_KEY, 1, 0, 8'h11, 1'b0);
		push(CMD_LOAD_COL_KEY, 1, 0, 8'h22, 1'b0);
		push(CMD_ENCRYPT, 0, 0, 8'h80, 1'b0);
		push(CMD_ENCRYPT, 0, 0, 8'hFF, 1'b0);
		push(CMD_DECRYPT, 0, 0, 8'hAA, 1'b0);
		push(CMD_DECRYPT, 0, 0, 8'h22, 1'b0);
		push(CMD_DECRYPT, 0, 0, 8'h11, 1'b0);
		push(CMD_DECRYPT, 0, 0, 8'h55, 1'b0);
		push(CMD_DECRYPT, 0, 0, 8'h00, 1'b0);
		push(CMD_DECRYPT, 0, 0, 8'h22, 1'b1);
		push(CMD_DECRYPT, 0, 0, 8'h11, 1'b0);
		push(CMD_ENCRYPT, 0, 0, 8'h80, 1'b1);
		push(CMD_LOAD_CELL, 1, 0, 8'h33, 1'b0);
		push(CMD_RESERVED_5, 7, 7, 8'hFF, 1'b1);
		push(CMD_RESERVED_6, 7, 7, 8'hFF, 1'b1);
		push(CMD_RESERVED_7, 7, 7, 8'hFF, 1'b1);
		push(CMD_DECRYPT, 0, 0, 8'h00, 1'b0);
		settle();

		for (int phase = 0; rand_count < RAND_ITEMS; phase++) begin
			if (phase < 6)
				set_size(4'(plan_rows[phase]), 4'(plan_cols[phase]));
			else
				set_size(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			tx_idle_on = 1'b1;
			rx_idle_on = 1'b1;
			load_square();
			settle();
			for (int b = 0; b < 4; b++) begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
				// receiver blocked while the sender keeps offering
				if (phase == 1 && b == 0) begin
					rx_hold_left = LONG_HOLD;
					tx_idle_on = 1'b0;
				end
				random_batch(BATCH_LEN);
				settle();
			end
		end

		mismatches += out_due.size();
		if (mismatches == 0)
			$display("tb_polybius_square_cipher: done, clean");
		else
			$display("tb_polybius_square_cipher: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
sv/pbsc_pkg.sv
sv/pbsc_cell.sv
sv/polybius_square_cipher.sv
sv/pbsc_checker.sv
bench/tb_polybius_square_cipher.sv
